// ----- hdl/char_cell_line_plot_raster_unit_assert.svh -----
// Assertion macros shared by the step-line plot raster RTL.
`ifndef CHAR_CELL_LINE_PLOT_RASTER_UNIT_ASSERT_SVH
`define CHAR_CELL_LINE_PLOT_RASTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CCLP_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("cclp assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CCLP_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("cclp assertion failed");

`endif

// ----- hdl/cclp_pkg.sv -----
// Word types, command codes, glyph codes and config indexes of the plot raster.
package cclp_pkg;

  localparam int VALUE_BITS = 16;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_BEGIN  = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  localparam logic [2:0] GL_EMPTY = 3'd0;
  localparam logic [2:0] GL_H     = 3'd1;
  localparam logic [2:0] GL_V     = 3'd2;
  localparam logic [2:0] GL_UL    = 3'd3;
  localparam logic [2:0] GL_UR    = 3'd4;
  localparam logic [2:0] GL_LL    = 3'd5;
  localparam logic [2:0] GL_LR    = 3'd6;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MAX    = 2'd2;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [6:0]            column;
    logic [4:0]            cell_row;
    logic [VALUE_BITS-1:0] sample_value;
    logic                  present;
    logic [1:0]            series_color;
  } in_word_t;

  typedef struct packed {
    logic [2:0] glyph;
    logic [1:0] color;
  } out_word_t;

  typedef struct packed {
    logic [2:0] glyph;
    logic [1:0] color;
  } cell_t;

endpackage

// ----- hdl/cclp_level_unit.sv -----
// Iterative level unit: shared multiplier for the numerator, then restoring division.
module cclp_level_unit #(
  parameter int MAX_ROWS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [$clog2(MAX_ROWS+1)-1:0]       height,
  input  logic [cclp_pkg::VALUE_BITS-1:0]     max_val,
  input  logic [cclp_pkg::VALUE_BITS-1:0]     value,
  output logic                                done,
  output logic [$clog2(MAX_ROWS)-1:0]         level
);

  localparam int VB = cclp_pkg::VALUE_BITS;
  localparam int HB = $clog2(MAX_ROWS + 1);
  localparam int QB = $clog2(MAX_ROWS);
  localparam int NW = VB + HB + 2;
  localparam int CW = $clog2(QB);

  typedef enum logic [1:0] {L_IDLE, L_MUL1, L_MUL2, L_DIV} lstate_t;

  lstate_t        st;
  logic [HB-1:0]  h_r;
  logic [VB-1:0]  m_r;
  logic [VB-1:0]  v_r;
  logic [NW-1:0]  acc;
  logic [NW-1:0]  dsh;
  logic [QB-1:0]  q;
  logic [CW-1:0]  cnt;

  logic [VB-1:0]  mul_a;
  logic [HB:0]    mul_b;
  logic [VB+HB:0] prod;
  logic           ge;

  // One multiplier serves both products of the numerator.
  assign mul_a = (st == L_MUL1) ? m_r : v_r;
  assign mul_b = (st == L_MUL1) ? ({h_r, 1'b0} - (HB+1)'(1)) : {1'b0, h_r - HB'(1)};
  assign prod  = {{(HB+1){1'b0}}, mul_a} * {{VB{1'b0}}, mul_b};
  assign ge    = (acc >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= L_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        L_IDLE: begin
          if (start) begin
            if (height == '0) begin
              level <= '0;
              done  <= 1'b1;
            end else if (max_val == '0) begin
              level <= QB'(height - HB'(1));
              done  <= 1'b1;
            end else begin
              h_r <= height;
              m_r <= max_val;
              v_r <= (value > max_val) ? max_val : value;
              st  <= L_MUL1;
            end
          end
        end
        L_MUL1: begin
          acc <= NW'(prod);
          st  <= L_MUL2;
        end
        L_MUL2: begin
          // The numerator never goes negative once the value is saturated.
          acc <= acc - {prod, 1'b0};
          dsh <= NW'({m_r, 1'b0}) << (QB - 1);
          cnt <= CW'(QB - 1);
          q   <= '0;
          st  <= L_DIV;
        end
        L_DIV: begin
          if (ge) begin
            acc <= acc - dsh;
          end
          q   <= {q[QB-2:0], ge};
          dsh <= dsh >> 1;
          cnt <= cnt - CW'(1);
          if (cnt == '0) begin
            level <= {q[QB-2:0], ge};
            done  <= 1'b1;
            st    <= L_IDLE;
          end
        end
        default: st <= L_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/cclp_cell_store.sv -----
// Cell memory: one write port and one registered read port.
module cclp_cell_store #(
  parameter int DEPTH = 3072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  cclp_pkg::cell_t          wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output cclp_pkg::cell_t          rdata
);

  cclp_pkg::cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/char_cell_line_plot_raster_unit.sv -----
// Top level of the text-mode step-line plot raster.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+------------------------------------
//  req     | in        | req_valid/req_ready | cmd, column, cell_row, value, ...
//  rsp     | out       | rsp_valid/rsp_ready | glyph, color (read command only)
//  cfg     | in        | cfg_we              | cfg_index, cfg_data (no wait)
//
// A read passes through S_RD1 and S_RD2 and loads its response word in S_RD2
// once the response register is free; begin and an absent sample leave the
// unit idle. A present sample waits in S_LEVEL on the level unit (no division
// when the height or the maximum is zero), whose restoring divider retires one
// quotient bit a cycle. Drawing then writes a gap cell per S_GAP step, a lone
// point in S_A, a flat adjacent step in S_A and S_C, and for a level change the
// corners in S_A and S_B, a vertical cell per S_V step and a closing S_V step
// for the leading horizontal of adjacent columns. Clear and reset sweep all
// MAX_COLUMNS*MAX_ROWS cells, one cell a cycle through the single write port;
// req_ready stays low meanwhile, but configuration writes are still taken.
// A pending response word does not stop new words; a second read waits for it.
module char_cell_line_plot_raster_unit #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  cclp_pkg::in_word_t   req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output cclp_pkg::out_word_t  rsp
);

`include "char_cell_line_plot_raster_unit_assert.svh"

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int WB    = $clog2(MAX_COLUMNS + 1);
  localparam int HB    = $clog2(MAX_ROWS + 1);
  localparam int RB    = $clog2(MAX_ROWS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD1, S_RD2, S_LEVEL, S_GAP, S_A, S_B, S_V, S_C
  } state_t;

  // Configuration registers.
  logic [7:0]  plot_width;
  logic [4:0]  plot_height;
  logic [15:0] max_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      plot_width  <= 8'd24;
      plot_height <= 5'd4;
      max_value   <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cclp_pkg::CFG_WIDTH:  plot_width  <= cfg_data[7:0];
        cclp_pkg::CFG_HEIGHT: plot_height <= cfg_data[4:0];
        cclp_pkg::CFG_MAX:    max_value   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective canvas size, clipped to the storage.
  logic [WB-1:0] eff_w;
  logic [HB-1:0] eff_h;
  assign eff_w = (32'(plot_width) > MAX_COLUMNS) ? WB'(MAX_COLUMNS) : WB'(plot_width);
  assign eff_h = (32'(plot_height) > MAX_ROWS) ? HB'(MAX_ROWS) : HB'(plot_height);

  // Sequencer state and series state.
  state_t             st;
  logic [AW-1:0]      clr_addr;
  cclp_pkg::in_word_t item;
  logic [RB-1:0]      prev_level;
  logic [6:0]         prev_column;
  logic               have_prev;
  logic [1:0]         draw_color;
  logic [RB-1:0]      now_lvl;
  logic [6:0]         gx;
  logic [RB-1:0]      vr;

  logic               accept;
  logic               lvl_start;
  logic               lvl_done;
  logic [RB-1:0]      lvl_level;

  assign req_ready = (st == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign lvl_start = accept && (req.cmd == cclp_pkg::CMD_SAMPLE) && req.present;

  cclp_level_unit #(.MAX_ROWS(MAX_ROWS)) u_level (
    .clk     (clk),
    .rst     (rst),
    .start   (lvl_start),
    .height  (eff_h),
    .max_val (max_value),
    .value   (req.sample_value),
    .done    (lvl_done),
    .level   (lvl_level)
  );

  // Geometry of the step from the previous point to the new one.
  logic [7:0]    col8;
  logic [7:0]    last1;
  logic          adjacent;
  logic          gap_needed;
  logic          down;
  logic [RB-1:0] lo;
  logic [RB-1:0] hi;

  assign col8       = {1'b0, item.column};
  assign last1      = {1'b0, prev_column} + 8'd1;
  assign adjacent   = (col8 == last1);
  assign gap_needed = (col8 > last1);
  assign down       = (prev_level < now_lvl);
  assign lo         = down ? prev_level : now_lvl;
  assign hi         = down ? now_lvl : prev_level;

  // The cell write of the current drawing step, at most one a cycle.
  logic          wr_en;
  logic [6:0]    wr_x;
  logic [RB-1:0] wr_y;
  logic [2:0]    wr_g;
  logic          wr_inside;

  always_comb begin
    wr_en = 1'b0;
    wr_x  = item.column;
    wr_y  = now_lvl;
    wr_g  = cclp_pkg::GL_H;
    case (st)
      S_GAP: begin
        // Bridge the gap at the previous level.
        wr_en = 1'b1;
        wr_x  = gx;
        wr_y  = prev_level;
      end
      S_A: begin
        wr_en = 1'b1;
        if (have_prev && (prev_level != now_lvl)) begin
          wr_y = lo;
          wr_g = down ? cclp_pkg::GL_UR : cclp_pkg::GL_UL;
        end else if (have_prev && adjacent) begin
          wr_x = prev_column;
        end
      end
      S_B: begin
        wr_en = 1'b1;
        wr_y  = hi;
        wr_g  = down ? cclp_pkg::GL_LL : cclp_pkg::GL_LR;
      end
      S_V: begin
        if (vr < hi) begin
          wr_en = 1'b1;
          wr_y  = vr;
          wr_g  = cclp_pkg::GL_V;
        end else if (adjacent) begin
          // The horizontal that leads into the level change.
          wr_en = 1'b1;
          wr_x  = prev_column;
          wr_y  = prev_level;
        end
      end
      S_C: begin
        wr_en = 1'b1;
      end
      default: ;
    endcase
  end

  assign wr_inside = (32'(wr_x) < 32'(eff_w)) && (32'(wr_y) < 32'(eff_h));

  // Store ports.
  logic            st_we;
  logic [AW-1:0]   st_waddr;
  cclp_pkg::cell_t st_wdata;
  logic [AW-1:0]   st_raddr;
  cclp_pkg::cell_t st_rdata;
  logic            rd_inside;

  assign st_we    = (st == S_CLEAR) || (wr_en && wr_inside);
  assign st_waddr = (st == S_CLEAR) ? clr_addr :
                    AW'(32'(wr_y) * MAX_COLUMNS + 32'(wr_x));
  assign st_wdata = (st == S_CLEAR) ? '0 :
                    cclp_pkg::cell_t'{glyph: wr_g, color: draw_color};
  assign st_raddr = AW'(32'(item.cell_row) * MAX_COLUMNS + 32'(item.column));
  assign rd_inside = (32'(item.column) < 32'(eff_w)) && (32'(item.cell_row) < 32'(eff_h));

  cclp_cell_store #(.DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Main sequencer with the series state and the response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_CLEAR;
      clr_addr    <= '0;
      prev_level  <= '0;
      prev_column <= '0;
      have_prev   <= 1'b0;
      draw_color  <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      // The end of a read reloads the response register itself.
      if (rsp_valid && rsp_ready && (st != S_RD2)) begin
        rsp_valid <= 1'b0;
      end
      unique case (st)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            st <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item <= req;
            unique case (req.cmd)
              cclp_pkg::CMD_CLEAR: begin
                clr_addr <= '0;
                st       <= S_CLEAR;
              end
              cclp_pkg::CMD_BEGIN: begin
                draw_color <= req.series_color;
                have_prev  <= 1'b0;
              end
              cclp_pkg::CMD_SAMPLE: begin
                if (req.present) begin
                  st <= S_LEVEL;
                end
              end
              cclp_pkg::CMD_READ: begin
                st <= S_RD1;
              end
            endcase
          end
        end
        S_RD1: st <= S_RD2;
        S_RD2: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp       <= rd_inside ? cclp_pkg::out_word_t'(st_rdata) : '0;
            st        <= S_IDLE;
          end
        end
        S_LEVEL: begin
          if (lvl_done) begin
            now_lvl <= lvl_level;
            if (have_prev && gap_needed) begin
              gx <= 7'(last1);
              st <= S_GAP;
            end else begin
              st <= S_A;
            end
          end
        end
        S_GAP: begin
          gx <= gx + 7'd1;
          if (({1'b0, gx} + 8'd1) >= col8) begin
            st <= S_A;
          end
        end
        S_A: begin
          if (have_prev && (prev_level != now_lvl)) begin
            st <= S_B;
          end else if (have_prev && adjacent) begin
            st <= S_C;
          end else begin
            prev_level  <= now_lvl;
            prev_column <= item.column;
            have_prev   <= 1'b1;
            st          <= S_IDLE;
          end
        end
        S_B: begin
          vr <= lo + RB'(1);
          st <= S_V;
        end
        S_V: begin
          if (vr < hi) begin
            vr <= vr + RB'(1);
          end else begin
            prev_level  <= now_lvl;
            prev_column <= item.column;
            have_prev   <= 1'b1;
            st          <= S_IDLE;
          end
        end
        S_C: begin
          prev_level  <= now_lvl;
          prev_column <= item.column;
          have_prev   <= 1'b1;
          st          <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // Every store write lands inside the storage.
  `CCLP_ASSERT_IMPLY(a_waddr_range, clk, rst, st_we, 32'(st_waddr) < DEPTH)
  // The level unit only reports while the sequencer waits for it.
  `CCLP_ASSERT_IMPLY(a_level_wait, clk, rst, lvl_done, st == S_LEVEL)
  // A response word is loaded only at the end of a read.
  `CCLP_ASSERT_IMPLY(a_rsp_source, clk, rst, $rose(rsp_valid), $past(st) == S_RD2)
  // The clearing sweep stops after the last cell.
  `CCLP_ASSERT_NEXT(a_clear_end, clk, rst,
    (st == S_CLEAR) && (clr_addr == AW'(DEPTH - 1)), st == S_IDLE)

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the text-mode step-line plot raster unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Canvas store geometry, kept equal to the parameters of the instance below.
  localparam int COLS  = 128;
  localparam int ROWS  = 24;
  localparam int CELLS = COLS * ROWS;

  // A clear sweeps every cell one per cycle, so it is the longest thing the
  // unit can still be busy with after the last read response has arrived.
  localparam int SETTLE_CYCLES = CELLS + 256;
  localparam int TAIL_CYCLES   = 200;

  // Series colors as the unit's users assign them.
  localparam logic [1:0] COLOR_WORK = 2'd1;
  localparam logic [1:0] COLOR_PEAK = 2'd2;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [1:0]          cfg_index = cclp_pkg::CFG_WIDTH;
  logic [15:0]         cfg_data  = '0;
  logic                req_valid = 1'b0;
  logic                req_ready;
  cclp_pkg::in_word_t  req       = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  cclp_pkg::out_word_t rsp;

  char_cell_line_plot_raster_unit #(
    .MAX_COLUMNS(COLS),
    .MAX_ROWS   (ROWS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Percent of cycles in which the request side holds back a word and the
  // response side refuses one. The test flow changes them between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Words sent that the unit acts on; gap samples are left out of the count.
  int words_sent  = 0;
  int error_count = 0;

  // Shadow of the canvas and of the series state, updated at each accepted
  // request word in the same order the unit sees them.
  bit [2:0]   glyph_mem [CELLS];
  bit [1:0]   color_mem [CELLS];
  int         last_row  = 0;
  int         prev_x    = 0;
  bit         have_last = 1'b0;
  logic [1:0] pen_color = 2'd0;

  // Shadow of the configuration registers, holding their reset values.
  int cv_width  = 24;
  int cv_height = 4;
  int cv_max    = 1;

  // Cells that outstanding read commands are expected to return, oldest first.
  cclp_pkg::out_word_t pending_cells [$];

  function automatic int eff_cols();
    return (cv_width > COLS) ? COLS : cv_width;
  endfunction

  function automatic int eff_rows();
    return (cv_height > ROWS) ? ROWS : cv_height;
  endfunction

  // Anything outside the canvas in use is silently dropped.
  function automatic void put_cell(int x, int y, logic [2:0] g);
    int idx;
    if (x < 0 || y < 0 || x >= eff_cols() || y >= eff_rows()) return;
    idx = y * COLS + x;
    glyph_mem[idx] = g;
    color_mem[idx] = pen_color;
  endfunction

  function automatic void hrun(int a, int b, int y);
    int lo;
    int hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    for (int x = lo; x <= hi; x++) put_cell(x, y, cclp_pkg::GL_H);
  endfunction

  // Row of a sample value: the top row is max, the bottom row zero, and a
  // value exactly half way between two rows lands on the lower one.
  function automatic int row_of_value(int unsigned v);
    longint unsigned h;
    longint unsigned m;
    longint unsigned vv;
    longint unsigned num;
    h  = eff_rows();
    m  = cv_max;
    vv = v;
    if (h == 0) return 0;
    if (m == 0) return int'(h - 1);
    if (vv > m) vv = m;
    num = m * (2 * h - 1) - 2 * vv * (h - 1);
    return int'(num / (2 * m));
  endfunction

  function automatic void plot_sample(int x, int unsigned v);
    int  now_row;
    int  lo;
    int  hi;
    bit  down;
    now_row = row_of_value(v);
    if (!have_last) begin
      put_cell(x, now_row, cclp_pkg::GL_H);
    end else begin
      // Columns skipped since the last sample are bridged at the old level.
      if (x > prev_x + 1) hrun(prev_x + 1, x - 1, last_row);
      if (last_row != now_row) begin
        down = last_row < now_row;
        lo   = down ? last_row : now_row;
        hi   = down ? now_row : last_row;
        put_cell(x, lo, down ? cclp_pkg::GL_UR : cclp_pkg::GL_UL);
        put_cell(x, hi, down ? cclp_pkg::GL_LL : cclp_pkg::GL_LR);
        for (int r = lo + 1; r < hi; r++) put_cell(x, r, cclp_pkg::GL_V);
        if (x == prev_x + 1) put_cell(prev_x, last_row, cclp_pkg::GL_H);
      end else if (x == prev_x + 1) begin
        hrun(prev_x, x, now_row);
      end else begin
        put_cell(x, now_row, cclp_pkg::GL_H);
      end
    end
    last_row  = now_row;
    prev_x    = x;
    have_last = 1'b1;
  endfunction

  // Applies one accepted request word to the shadow canvas and queues the
  // cell that a read command must return.
  function automatic void canvas_step(cclp_pkg::in_word_t w);
    cclp_pkg::out_word_t rd_cell;
    int                  idx;
    case (w.cmd)
      cclp_pkg::CMD_CLEAR: begin
        foreach (glyph_mem[i]) begin
          glyph_mem[i] = '0;
          color_mem[i] = '0;
        end
      end
      cclp_pkg::CMD_BEGIN: begin
        pen_color = w.series_color;
        have_last = 1'b0;
      end
      cclp_pkg::CMD_SAMPLE: begin
        if (w.present) plot_sample(int'(w.column), int'(w.sample_value));
      end
      default: begin
        rd_cell = '0;
        if (int'(w.column) < eff_cols() && int'(w.cell_row) < eff_rows()) begin
          idx           = int'(w.cell_row) * COLS + int'(w.column);
          rd_cell.glyph = glyph_mem[idx];
          rd_cell.color = color_mem[idx];
        end
        pending_cells.push_back(rd_cell);
      end
    endcase
  endfunction

  // The response side takes or refuses a word at random each cycle.
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compares each response word with the oldest expected cell, then feeds
  // the request word accepted at this edge to the shadow canvas.
  always @(posedge clk) begin : scoreboard
    cclp_pkg::out_word_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (pending_cells.size() == 0) begin
          $error("response word with nothing expected: glyph %0d, color %0d",
                 rsp.glyph, rsp.color);
          error_count++;
        end else begin
          want = pending_cells.pop_front();
          if (rsp.glyph !== want.glyph) begin
            $error("glyph: expected %0d, actual %0d", want.glyph, rsp.glyph);
            error_count++;
          end
          if (rsp.color !== want.color) begin
            $error("color: expected %0d, actual %0d", want.color, rsp.color);
            error_count++;
          end
        end
      end
      if (req_valid && req_ready) canvas_step(req);
    end
  end

  // Sends one request word and returns at the edge that accepts it. Valid is
  // left high so that a following word can go out in the very next cycle;
  // the next idle cycle or pause is what lowers it.
  task automatic send_word(input cclp_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (!req_ready);
    if (!(w.cmd == cclp_pkg::CMD_SAMPLE && !w.present)) words_sent++;
  endtask

  // A word with random content in every field, so that the fields a command
  // does not use still see all their bits move.
  function automatic cclp_pkg::in_word_t shaped_word(logic [1:0] cmd);
    logic [63:0]        r;
    cclp_pkg::in_word_t w;
    r     = {$urandom, $urandom};
    w     = r[$bits(cclp_pkg::in_word_t)-1:0];
    w.cmd = cmd;
    return w;
  endfunction

  task automatic send_clear();
    send_word(shaped_word(cclp_pkg::CMD_CLEAR));
  endtask

  task automatic send_begin(input logic [1:0] color);
    cclp_pkg::in_word_t w;
    w              = shaped_word(cclp_pkg::CMD_BEGIN);
    w.series_color = color;
    send_word(w);
  endtask

  task automatic send_sample(input int col, input int unsigned value, input bit pres);
    cclp_pkg::in_word_t w;
    w              = shaped_word(cclp_pkg::CMD_SAMPLE);
    w.column       = 7'(col);
    w.sample_value = 16'(value);
    w.present      = pres;
    send_word(w);
  endtask

  task automatic send_read(input int col, input int row);
    cclp_pkg::in_word_t w;
    w          = shaped_word(cclp_pkg::CMD_READ);
    w.column   = 7'(col);
    w.cell_row = 5'(row);
    send_word(w);
  endtask

  // Stops sending, waits for every expected cell, then gives the unit time
  // to finish a sample or a clear that produces no response.
  task automatic drain_and_settle();
    req_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers back to back once the unit is idle. Unused
  // upper data bits carry noise, since each register keeps only its width.
  task automatic set_canvas(input int w, input int h, input int m);
    drain_and_settle();
    cv_width  = w & 8'hFF;
    cv_height = h & 5'h1F;
    cv_max    = m & 16'hFFFF;
    cfg_we    <= 1'b1;
    cfg_index <= cclp_pkg::CFG_WIDTH;
    cfg_data  <= (16'($urandom) & 16'hFF00) | 16'(cv_width);
    @(posedge clk);
    cfg_index <= cclp_pkg::CFG_HEIGHT;
    cfg_data  <= (16'($urandom) & 16'hFFE0) | 16'(cv_height);
    @(posedge clk);
    cfg_index <= cclp_pkg::CFG_MAX;
    cfg_data  <= 16'(cv_max);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Right after reset and after a clear every cell must read back empty,
  // including cells beyond the canvas in use.
  task automatic test_blank_canvas();
    send_read(0, 0);
    send_read(23, 3);
    send_read(127, 31);
    send_clear();
    send_read(5, 2);
  endtask

  // One short series on a small canvas that walks through the drawing rules:
  // a first point, a rise of the full height, a flat step, a bridged gap,
  // an absent sample, a column that goes backward with a saturated value,
  // and a column off the right edge.
  task automatic test_step_shapes();
    set_canvas(16, 8, 100);
    send_begin(COLOR_WORK);
    send_sample(0, 0, 1'b1);
    send_sample(1, 100, 1'b1);
    send_sample(2, 100, 1'b1);
    send_sample(5, 50, 1'b1);
    send_sample(6, 0, 1'b0);
    send_sample(4, 65535, 1'b1);
    send_sample(20, 30, 1'b1);
    send_read(1, 0);
    send_read(1, 7);
    send_read(1, 3);
    send_read(3, 0);
    send_read(5, 3);
    send_read(4, 0);
  endtask

  // Register extremes: an empty canvas, a zero maximum that puts every
  // sample on the bottom row, sizes above the store that get clipped, color
  // codes outside the usual two, and a clear of a fully sized canvas.
  task automatic test_canvas_extremes();
    set_canvas(0, 0, 0);
    send_begin(2'd3);
    send_sample(3, 5, 1'b1);
    send_read(3, 0);
    set_canvas(255, 31, 0);
    send_sample(127, 12345, 1'b1);
    send_read(127, 23);
    send_read(127, 0);
    send_read(126, 0);
    send_begin(2'd0);
    send_sample(0, 0, 1'b1);
    send_read(0, 23);
    set_canvas(128, 24, 65535);
    send_clear();
    send_read(127, 0);
  endtask

  function automatic int unsigned pick_value();
    case ($urandom_range(4))
      0:       return 0;
      1:       return cv_max;
      2:       return $urandom_range(65535);
      3:       return $urandom_range(cv_max);
      default: return (cv_max + $urandom_range(3) > 65535) ? 65535
                                                             : cv_max + $urandom_range(3);
    endcase
  endfunction

  // One burst of random traffic. Most bursts are a series of samples that
  // mostly move right one column at a time, followed by reads around the
  // drawn part; the rest are lone reads, random words and the odd clear.
  task automatic random_burst();
    int pick;
    int col;
    int first;
    int rows;
    int n;
    int step;
    pick = $urandom_range(99);
    rows = (eff_rows() > 0) ? eff_rows() : 1;
    if (pick < 2) begin
      send_clear();
    end else if (pick < 55) begin
      if ($urandom_range(3) != 0) begin
        if ($urandom_range(9) == 0) send_begin(2'($urandom_range(3)));
        else send_begin($urandom_range(1) ? COLOR_WORK : COLOR_PEAK);
      end
      col   = $urandom_range(0, (eff_cols() > 0) ? eff_cols() - 1 : 127);
      first = col;
      n     = $urandom_range(1, 10);
      repeat (n) begin
        send_sample(col, pick_value(), $urandom_range(9) != 0);
        step = $urandom_range(99);
        if (step < 70)      col = col + 1;
        else if (step < 90) col = col + $urandom_range(2, 4);
        else if (step < 98) col = col - $urandom_range(0, 3);
        else                col = col + $urandom_range(10, 40);
        if (col < 0)   col = 0;
        if (col > 127) col = 127;
      end
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(7) == 0) send_read($urandom_range(127), $urandom_range(31));
        else send_read($urandom_range(first, col), $urandom_range(rows - 1));
      end
    end else if (pick < 80) begin
      send_read($urandom_range(127), $urandom_range(31));
    end else begin
      send_word(shaped_word($urandom_range(7) == 0 ? cclp_pkg::CMD_CLEAR
                                                   : 2'($urandom_range(1, 3))));
    end
  endtask

  // Six phases of random traffic on different canvases. The first two idle
  // the sender lightly and the receiver heavily, the next two the other way
  // round, and the last two run with no idling at all. Each phase change
  // waits for every expected cell first.
  task automatic test_random_plots();
    int target;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (ph)
        0: set_canvas(24, 4, 1);
        1: set_canvas(128, 24, 65535);
        2: set_canvas(8, 4, 3);
        3: set_canvas($urandom_range(8, 128), $urandom_range(4, 24),
                      $urandom_range(1, 65535));
        4: set_canvas(40, 12, 1000);
        default: set_canvas($urandom_range(8, 128), $urandom_range(4, 24),
                            $urandom_range(1, 50));
      endcase
      target = words_sent + 145;
      while (words_sent < target) random_burst();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 64;
    test_blank_canvas();
    test_step_shapes();
    test_canvas_extremes();
    test_random_plots();
    // Let the last responses and any sample still in progress come out, so
    // that a stray response word is caught too.
    req_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a missing response ends the run here.
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/cclp_pkg.sv
hdl/cclp_level_unit.sv
hdl/cclp_cell_store.sv
hdl/char_cell_line_plot_raster_unit.sv
verif/testbench.sv
